>>> design/mtdm_pkg.sv
package mtdm_pkg;

	// raw hash before the modulo: ((6 * 255) << 2) + 255 + 4095 fits in 14 bits
	localparam int HASH_W = 14;
	localparam int BSUM_W = 11;
	localparam int PORT_W = 8;
	localparam int VLAN_W = 12;
	localparam int MAC_W  = 48;
	localparam int PV_W   = PORT_W + VLAN_W;
	localparam int SLOT_OUT_W = 10;

	// fixed-point reciprocal scale for the slot modulo
	localparam int RECIP_SHIFT = 30;

	typedef enum logic [1:0] {
		CMD_LOOKUP = 2'd0,
		CMD_ADD    = 2'd1,
		CMD_DELETE = 2'd2
	} cmd_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_MUL,
		ST_MOD,
		ST_READ,
		ST_CHECK
	} state_t;

	typedef struct packed {
		logic              valid;
		logic [PV_W-1:0]   port_vlan;
		logic [MAC_W-1:0]  mac;
	} entry_t;

endpackage

>>> design/mac_table_direct_mapped.sv
// direct-mapped layer-2 mac table
// commands arrive as transactions on the s_ group: lookup, add or delete of a
// (port, vlan, mac) entry; each command gives exactly one result transaction
// on the m_ group with status, hit and the hashed slot index
// the slot is ((sum of mac bytes) << 2) + port + vlan, modulo TABLE_SLOTS;
// the modulo uses a constant reciprocal multiply and one correcting subtract
// a command runs through these steps in order: the hash is registered at
// acceptance, then reciprocal multiply, remainder, memory read, and compare
// with write back; the next command is taken only after the compare step, so
// the table is through with one command before it takes the next, as set by
// this sequence around the single-port table memory
// the result sits in an output register; while it waits, the next command is
// still accepted and runs up to the compare step, where it holds until the
// output register is free, so a stalled receiver stalls the table update too
// after reset a clearing pass writes every slot invalid, one per cycle, while
// s_tready stays low
module mac_table_direct_mapped #(
	parameter int TABLE_SLOTS = 1024
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [71:0] s_tdata,  // cmd[1:0], port_number[9:2], vlan_id[21:10],
	                              // mac_address[69:22], zero pad[71:70]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata   // status[0], hit[1], slot[11:2], zero pad[15:12]
);
	import mtdm_pkg::*;

	localparam int SLOT_W = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
	localparam int R_W    = SLOT_W + 1;
	localparam longint RECIP = (64'd1 << RECIP_SHIFT) / TABLE_SLOTS;
	localparam int PROD_W = HASH_W + RECIP_SHIFT;

	// state machine
	state_t state_q, state_d;

	// table memory
	entry_t tbl_mem [TABLE_SLOTS];
	entry_t rd_q;

	// command registers
	logic [1:0]        cmd_q;
	logic [PV_W-1:0]   pv_q;
	logic [MAC_W-1:0]  mac_q;
	logic [HASH_W-1:0] hash_q;
	logic [HASH_W-1:0] quot_q;
	logic [R_W-1:0]    rem_q;
	logic [SLOT_W-1:0] slot_q;
	logic [SLOT_W-1:0] clr_cnt_q;

	// output register
	logic              m_tvalid_q;
	logic              status_q;
	logic              hit_q;
	logic [SLOT_OUT_W-1:0] slot_out_q;

	// combinational
	logic [BSUM_W-1:0] byte_sum;
	logic [HASH_W-1:0] hash_in;
	logic [PROD_W-1:0] recip_prod;
	logic [31:0]       rem_full;
	logic [SLOT_W-1:0] slot_mod;
	logic [31:0]       slot_ext;
	logic              s_accept;
	logic              out_free;
	logic              check_go;
	logic              clr_done;
	logic              hit_c;
	logic              status_c;
	logic              wr_en;
	entry_t            wr_entry;
	logic [SLOT_W-1:0] wr_addr;

	assign s_accept = s_tvalid && s_tready;
	assign out_free = !m_tvalid_q || m_tready;
	assign check_go = (state_q == ST_CHECK) && out_free;
	assign clr_done = (clr_cnt_q == SLOT_W'(TABLE_SLOTS - 1));

	// hash of the incoming command
	always_comb begin
		byte_sum = '0;
		for (int i = 0; i < 6; i++) begin
			byte_sum = byte_sum + BSUM_W'(s_tdata[22 + 8*i +: 8]);
		end
		hash_in = HASH_W'({byte_sum, 2'b00}) + HASH_W'(s_tdata[9:2])
		        + HASH_W'(s_tdata[21:10]);
	end

	// quotient estimate is exact or one low
	assign recip_prod = PROD_W'(hash_q) * PROD_W'(RECIP);
	assign rem_full   = 32'(hash_q) - 32'(quot_q) * 32'(TABLE_SLOTS);
	// remainder below twice the table size, one correcting subtract
	assign slot_mod   = (rem_q >= R_W'(TABLE_SLOTS))
	                  ? SLOT_W'(rem_q - R_W'(TABLE_SLOTS)) : SLOT_W'(rem_q);

	// compare against the slot read back and decide the update
	always_comb begin
		hit_c    = rd_q.valid && (rd_q.port_vlan == pv_q) && (rd_q.mac == mac_q);
		wr_en    = 1'b0;
		wr_entry = rd_q;
		status_c = !hit_c;
		case (cmd_q)
			CMD_ADD: begin
				status_c = hit_c;
				if (!hit_c) begin
					wr_en    = 1'b1;
					wr_entry = '{valid: 1'b1, port_vlan: pv_q, mac: mac_q};
				end
			end
			CMD_DELETE: begin
				status_c = !hit_c;
				if (hit_c) begin
					wr_en          = 1'b1;
					wr_entry.valid = 1'b0;
				end
			end
			default: begin
				status_c = !hit_c;  // lookup, unused code acts the same
			end
		endcase
		if (state_q == ST_CLEAR) begin
			wr_en    = 1'b1;
			wr_entry = '0;
			wr_addr  = clr_cnt_q;
		end else begin
			wr_en   = wr_en && check_go;
			wr_addr = slot_q;
		end
	end

	// next state and handshake
	always_comb begin
		state_d  = state_q;
		s_tready = 1'b0;
		unique case (state_q)
			ST_CLEAR: begin
				if (clr_done) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					state_d = ST_MUL;
				end
			end
			ST_MUL:  state_d = ST_MOD;
			ST_MOD:  state_d = ST_READ;
			ST_READ: state_d = ST_CHECK;
			ST_CHECK: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_CLEAR;
			clr_cnt_q  <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_CLEAR && !clr_done) begin
				clr_cnt_q <= clr_cnt_q + SLOT_W'(1);
			end
			if (check_go) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (s_accept) begin
			cmd_q  <= s_tdata[1:0];
			pv_q   <= {s_tdata[9:2], s_tdata[21:10]};
			mac_q  <= s_tdata[69:22];
			hash_q <= hash_in;
		end
		if (state_q == ST_MUL) begin
			quot_q <= recip_prod[PROD_W-1 -: HASH_W];
		end
		if (state_q == ST_MOD) begin
			rem_q <= rem_full[R_W-1:0];
		end
		if (state_q == ST_READ) begin
			slot_q <= slot_mod;
		end
		if (check_go) begin
			status_q   <= status_c;
			hit_q      <= hit_c;
			slot_out_q <= slot_ext[SLOT_OUT_W-1:0];
		end
	end

	assign slot_ext = 32'(slot_q);

	// table memory, one write and one registered read port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			tbl_mem[wr_addr] <= wr_entry;
		end
		if (state_q == ST_READ) begin
			rd_q <= tbl_mem[slot_mod];
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {4'b0000, slot_out_q, hit_q, status_q};

endmodule

>>> tb/sv/mac_table_direct_mapped_tb.sv
module mac_table_direct_mapped_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import mtdm_pkg::*;

	localparam int         TBL_SLOTS   = 1024;
	localparam logic [1:0] CMD_UNUSED  = 2'd3;   // undefined code, behaves as a lookup
	localparam int         N_DIRECTED  = 23;
	localparam int         N_CHUNKS    = 10;
	localparam int         CHUNK_ITEMS = 183;
	localparam int         BURST_ITEMS = 24;
	localparam int         RX_HOLD     = 150;    // long receiver stall, in cycles
	localparam int         POOL_DEPTH  = 32;
	localparam int         TAIL_CYCLES = 20;     // margin after the last expected result
	localparam int         MAX_REPORTS = 10;

	// one command as it travels on s_tdata
	typedef struct packed {
		logic [1:0]        op;
		logic [PORT_W-1:0] port;
		logic [VLAN_W-1:0] vlan;
		logic [MAC_W-1:0]  mac;
	} mac_cmd_t;

	// one result as it travels on m_tdata
	typedef struct packed {
		logic                  status;
		logic                  hit;
		logic [SLOT_OUT_W-1:0] slot;
	} mac_result_t;

	// directed row: command, then a typed-in result where typed is set
	typedef struct packed {
		logic [1:0]            op;
		logic [PORT_W-1:0]     port;
		logic [VLAN_W-1:0]     vlan;
		logic [MAC_W-1:0]      mac;
		logic                  typed;
		logic                  status;
		logic                  hit;
		logic [SLOT_OUT_W-1:0] slot;
	} dir_row_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [71:0] s_tdata;
	logic        m_tvalid;
	logic        m_tready;
	logic [15:0] m_tdata;

	// shadow copy of the table
	logic              shadow_valid [TBL_SLOTS];
	logic [MAC_W-1:0]  shadow_mac   [TBL_SLOTS];
	logic [PV_W-1:0]   shadow_pv    [TBL_SLOTS];

	mac_result_t pending_results[$];

	// pacing controls shared between the stimulus and the receiver
	bit tx_eager;
	bit rx_eager;
	bit rx_hold_req;

	int fail_count;
	int results_seen;
	int n_lookup_hit, n_lookup_miss, n_add_new, n_add_dup, n_del_hit, n_del_miss;

	dir_row_t directed_rows [0:N_DIRECTED-1] = '{
		// empty table, then add / duplicate / lookup / delete on the all-zero key
		'{CMD_LOOKUP, 8'd0,   12'd0,    48'h0,            1'b1, 1'b1, 1'b0, 10'd0},
		'{CMD_ADD,    8'd0,   12'd0,    48'h0,            1'b1, 1'b0, 1'b0, 10'd0},
		'{CMD_ADD,    8'd0,   12'd0,    48'h0,            1'b1, 1'b1, 1'b1, 10'd0},
		'{CMD_LOOKUP, 8'd0,   12'd0,    48'h0,            1'b1, 1'b0, 1'b1, 10'd0},
		'{CMD_UNUSED, 8'd0,   12'd0,    48'h0,            1'b1, 1'b0, 1'b1, 10'd0},
		'{CMD_DELETE, 8'd0,   12'd0,    48'h0,            1'b1, 1'b0, 1'b1, 10'd0},
		'{CMD_DELETE, 8'd0,   12'd0,    48'h0,            1'b1, 1'b1, 1'b0, 10'd0},
		'{CMD_UNUSED, 8'd0,   12'd0,    48'h0,            1'b1, 1'b1, 1'b0, 10'd0},
		// all fields at their maximum: raw hash 10470 wraps to slot 230
		'{CMD_ADD,    8'd255, 12'd4095, 48'hFFFF_FFFF_FFFF, 1'b1, 1'b0, 1'b0, 10'd230},
		'{CMD_LOOKUP, 8'd255, 12'd4095, 48'hFFFF_FFFF_FFFF, 1'b1, 1'b0, 1'b1, 10'd230},
		'{CMD_LOOKUP, 8'd255, 12'd4095, 48'hFFFF_FFFF_FFFE, 1'b0, 1'b0, 1'b0, 10'd0},
		// port and vlan swapped land on one slot: second add evicts the first
		'{CMD_ADD,    8'd1,   12'd0,    48'h0,            1'b0, 1'b0, 1'b0, 10'd0},
		'{CMD_ADD,    8'd0,   12'd1,    48'h0,            1'b0, 1'b0, 1'b0, 10'd0},
		'{CMD_LOOKUP, 8'd1,   12'd0,    48'h0,            1'b0, 1'b0, 1'b0, 10'd0},
		'{CMD_LOOKUP, 8'd0,   12'd1,    48'h0,            1'b0, 1'b0, 1'b0, 10'd0},
		'{CMD_DELETE, 8'd1,   12'd0,    48'h0,            1'b0, 1'b0, 1'b0, 10'd0},
		// same byte sum, different mac: same slot, no match
		'{CMD_ADD,    8'd0,   12'd0,    48'h0000_0000_0100, 1'b0, 1'b0, 1'b0, 10'd0},
		'{CMD_LOOKUP, 8'd0,   12'd0,    48'h0000_0000_0001, 1'b0, 1'b0, 1'b0, 10'd0},
		// alternating bit patterns
		'{CMD_ADD,    8'hAA,  12'hAAA,  48'hAAAA_AAAA_AAAA, 1'b0, 1'b0, 1'b0, 10'd0},
		'{CMD_ADD,    8'h55,  12'h555,  48'h5555_5555_5555, 1'b0, 1'b0, 1'b0, 10'd0},
		'{CMD_LOOKUP, 8'hAA,  12'hAAA,  48'hAAAA_AAAA_AAAA, 1'b0, 1'b0, 1'b0, 10'd0},
		'{CMD_DELETE, 8'd255, 12'd4095, 48'hFFFF_FFFF_FFFF, 1'b1, 1'b0, 1'b1, 10'd230},
		'{CMD_LOOKUP, 8'd255, 12'd4095, 48'hFFFF_FFFF_FFFF, 1'b1, 1'b1, 1'b0, 10'd230}
	};

	mac_table_direct_mapped #(
		.TABLE_SLOTS(TBL_SLOTS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// hashed slot: byte sum shifted by two, plus port and vlan, wrapped to the table
	function automatic logic [SLOT_OUT_W-1:0] hash_slot(input mac_cmd_t c);
		int unsigned byte_sum;
		byte_sum = 0;
		for (int i = 0; i < 6; i++)
			byte_sum += c.mac[8*i +: 8];
		return SLOT_OUT_W'(((byte_sum << 2) + c.port + c.vlan) % TBL_SLOTS);
	endfunction

	// applies one command to the shadow table and returns the result it gives
	function automatic mac_result_t table_apply(input mac_cmd_t c);
		mac_result_t res;
		int unsigned idx;
		logic match;
		idx = (((c.mac[7:0] + c.mac[15:8] + c.mac[23:16] + c.mac[31:24] + c.mac[39:32]
			+ c.mac[47:40]) << 2) + c.port + c.vlan) % TBL_SLOTS;
		match = shadow_valid[idx] && shadow_pv[idx] == {c.port, c.vlan}
			&& shadow_mac[idx] == c.mac;
		res.hit = match;
		res.slot = hash_slot(c);
		case (c.op)
			CMD_ADD: begin
				res.status = match;
				if (match) begin
					n_add_dup++;
				end else begin
					shadow_valid[idx] = 1'b1;
					shadow_mac[idx] = c.mac;
					shadow_pv[idx] = {c.port, c.vlan};
					n_add_new++;
				end
			end
			CMD_DELETE: begin
				res.status = !match;
				if (match) begin
					shadow_valid[idx] = 1'b0;
					n_del_hit++;
				end else begin
					n_del_miss++;
				end
			end
			default: begin
				// lookup, and the unused code behaves the same
				res.status = !match;
				if (match) n_lookup_hit++;
				else n_lookup_miss++;
			end
		endcase
		return res;
	endfunction

	// offers one command transaction; the expectation is queued once it is taken
	task automatic offer(input mac_cmd_t c, input logic typed, input mac_result_t fixed);
		int gap;
		mac_result_t predicted;
		gap = tx_eager ? 0 : $urandom_range(0, 9);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {2'b00, c.mac, c.vlan, c.port, c.op};
		do @(posedge clk); while (!s_tready);
		predicted = table_apply(c);
		pending_results.push_back(typed ? fixed : predicted);
	endtask

	// sender pause: nothing offered until every queued result has arrived
	task automatic wait_drained();
		s_tvalid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
	endtask

	// receiver: random stalls per result, eager stretches, and one long hold
	initial begin
		int gap;
		bit held;
		held = 1'b0;
		m_tready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			if (rx_hold_req && !held) begin
				held = 1'b1;
				m_tready <= 1'b0;
				repeat (RX_HOLD) @(posedge clk);
			end
			gap = rx_eager ? 0 : $urandom_range(0, 9);
			if (gap > 0) begin
				m_tready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
		end
	end

	// result checker: every result transaction against the oldest expectation
	always @(posedge clk) begin
		mac_result_t got, want;
		if (arst_n && m_tvalid && m_tready) begin
			got = '{status: m_tdata[0], hit: m_tdata[1], slot: m_tdata[11:2]};
			results_seen++;
			if (pending_results.size() == 0) begin
				fail_count++;
				if (fail_count <= MAX_REPORTS)
					$display("[%0t] unexpected result: status=%0b hit=%0b slot=%0d",
						$realtime, got.status, got.hit, got.slot);
			end else begin
				want = pending_results.pop_front();
				if (got !== want) begin
					fail_count++;
					if (fail_count <= MAX_REPORTS)
						$display({"[%0t] result mismatch: expected status=%0b hit=%0b slot=%0d,",
							" got status=%0b hit=%0b slot=%0d"}, $realtime, want.status,
							want.hit, want.slot, got.status, got.hit, got.slot);
				end
			end
		end
	end

	// hard limit, far above the slowest correct run
	initial begin
		#4_000_000;
		$display("Simulation FAILED");
		$finish;
	end

	initial begin
		mac_cmd_t c;
		mac_result_t fixed;
		mac_cmd_t key_pool [POOL_DEPTH];
		int pool_fill;
		int pick;
		int w;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		tx_eager = 1'b0;
		rx_eager = 1'b0;
		rx_hold_req = 1'b0;
		pool_fill = 0;
		for (int i = 0; i < TBL_SLOTS; i++) begin
			shadow_valid[i] = 1'b0;
			shadow_mac[i] = '0;
			shadow_pv[i] = '0;
		end
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// directed table; s_tready stays low through the clearing pass
		for (int k = 0; k < N_DIRECTED; k++) begin
			c = '{op: directed_rows[k].op, port: directed_rows[k].port,
				vlan: directed_rows[k].vlan, mac: directed_rows[k].mac};
			fixed = '{status: directed_rows[k].status, hit: directed_rows[k].hit,
				slot: directed_rows[k].slot};
			offer(c, directed_rows[k].typed, fixed);
		end
		wait_drained();

		// random commands: mostly reused keys so adds, hits and deletes interact
		for (int chunk = 0; chunk < N_CHUNKS; chunk++) begin
			tx_eager = ($urandom_range(0, 3) == 0);
			rx_eager = ($urandom_range(0, 3) == 0);
			if (chunk == 3)
				wait_drained();
			if (chunk == 5) begin
				// back-to-back commands against a stalled receiver fill the pipeline
				tx_eager = 1'b1;
				rx_hold_req = 1'b1;
			end
			for (int n = 0; n < CHUNK_ITEMS; n++) begin
				if (chunk == 5 && n == BURST_ITEMS)
					tx_eager = 1'b0;
				pick = $urandom_range(0, 99);
				if (pool_fill > 0 && pick < 65) begin
					c = key_pool[$urandom_range(0, pool_fill - 1)];
				end else begin
					c.port = PORT_W'($urandom);
					c.vlan = VLAN_W'($urandom);
					c.mac = MAC_W'({$urandom, $urandom});
					if (pick >= 85) begin
						// tiny key space: many keys share a slot
						c.port = PORT_W'($urandom_range(0, 3));
						c.vlan = VLAN_W'($urandom_range(0, 3));
						c.mac = MAC_W'($urandom_range(0, 3)) << (8 * $urandom_range(0, 5));
					end
					if (pool_fill < POOL_DEPTH) begin
						key_pool[pool_fill] = c;
						pool_fill++;
					end else begin
						key_pool[$urandom_range(0, POOL_DEPTH - 1)] = c;
					end
				end
				pick = $urandom_range(0, 99);
				if (pick < 40) c.op = CMD_ADD;
				else if (pick < 70) c.op = CMD_LOOKUP;
				else if (pick < 95) c.op = CMD_DELETE;
				else c.op = CMD_UNUSED;
				offer(c, 1'b0, '0);
			end
		end
		s_tvalid <= 1'b0;

		// wait for the stragglers, bounded; anything left over is a failure
		for (w = 0; w < 5000 && pending_results.size() != 0; w++)
			@(posedge clk);
		fail_count += pending_results.size();
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("covered %0d results: lookups %0d hit / %0d miss, adds %0d new / %0d dup,",
			results_seen, n_lookup_hit, n_lookup_miss, n_add_new, n_add_dup);
		$display("deletes %0d hit / %0d miss, slot collisions, unused code, full stall, %0d errors",
			n_del_hit, n_del_miss, fail_count);
		if (fail_count == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule

>>> filelist.f
design/mtdm_pkg.sv
design/mac_table_direct_mapped.sv
tb/sv/mac_table_direct_mapped_tb.sv
